// ===== sv/dap_pkg.sv =====
// dap_pkg: operation codes, combining-class codes and placement selects
// for the diacritic attach placer. No dependencies.
package dap_pkg;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_PLACE = 2'd2;

    localparam int          FONT_BITS         = 12;
    localparam int          GAP_BITS          = 9;
    localparam int          FONT_HEIGHT_RESET = 16;
    localparam int          GAP_DIVISOR       = 10;
    localparam int          GAP_RECIP         = 3277;
    localparam int          GAP_SHIFT         = 15;
    localparam int          GAP_PROD_BITS     = FONT_BITS + GAP_SHIFT;
    localparam logic [GAP_BITS-1:0] GAP_RESET = GAP_BITS'(FONT_HEIGHT_RESET / GAP_DIVISOR);

    localparam logic [7:0] CC_ATTB_LEFT       = 8'd200;
    localparam logic [7:0] CC_ATTB            = 8'd202;
    localparam logic [7:0] CC_ATTB_RIGHT      = 8'd204;
    localparam logic [7:0] CC_ATT_LEFT        = 8'd208;
    localparam logic [7:0] CC_ATT_RIGHT       = 8'd210;
    localparam logic [7:0] CC_ATTA_LEFT       = 8'd212;
    localparam logic [7:0] CC_ATTA            = 8'd214;
    localparam logic [7:0] CC_ATTA_RIGHT      = 8'd216;
    localparam logic [7:0] CC_BELOW_LEFT      = 8'd218;
    localparam logic [7:0] CC_BELOW           = 8'd220;
    localparam logic [7:0] CC_BELOW_RIGHT     = 8'd222;
    localparam logic [7:0] CC_LEFT            = 8'd224;
    localparam logic [7:0] CC_RIGHT           = 8'd226;
    localparam logic [7:0] CC_ABOVE_LEFT      = 8'd228;
    localparam logic [7:0] CC_ABOVE           = 8'd230;
    localparam logic [7:0] CC_ABOVE_RIGHT     = 8'd232;
    localparam logic [7:0] CC_FATHATAN        = 8'd27;
    localparam logic [7:0] CC_DAMMATAN        = 8'd28;
    localparam logic [7:0] CC_KASRATAN        = 8'd29;
    localparam logic [7:0] CC_FATHA           = 8'd30;
    localparam logic [7:0] CC_DAMMA           = 8'd31;
    localparam logic [7:0] CC_KASRA           = 8'd32;
    localparam logic [7:0] CC_SHADDA          = 8'd33;
    localparam logic [7:0] CC_SUKUN           = 8'd34;

    typedef enum logic [2:0] {
        V_KEEP,
        V_BELOW,
        V_ABOVE,
        V_BELOW_GAP,
        V_ABOVE_GAP
    } vsel_t;

    typedef enum logic [2:0] {
        H_LEFT,
        H_CENTER,
        H_RIGHT,
        H_LEFT_OF,
        H_RIGHT_OF,
        H_LEFT_OF_GAP,
        H_RIGHT_OF_GAP
    } hsel_t;

    typedef struct packed {
        vsel_t vsel;
        hsel_t hsel;
    } place_sel_t;

    function automatic place_sel_t class_decode(input logic [7:0] cc);
        place_sel_t sel;
        sel.vsel = V_KEEP;
        sel.hsel = H_CENTER;
        case (cc)
            CC_ATTB_LEFT:   begin sel.vsel = V_BELOW;     sel.hsel = H_LEFT;   end
            CC_ATTB:        begin sel.vsel = V_BELOW;     sel.hsel = H_CENTER; end
            CC_ATTB_RIGHT:  begin sel.vsel = V_BELOW;     sel.hsel = H_RIGHT;  end
            CC_ATT_LEFT:    begin sel.vsel = V_KEEP;      sel.hsel = H_LEFT_OF;  end
            CC_ATT_RIGHT:   begin sel.vsel = V_KEEP;      sel.hsel = H_RIGHT_OF; end
            CC_ATTA_LEFT:   begin sel.vsel = V_ABOVE;     sel.hsel = H_LEFT;   end
            CC_ATTA:        begin sel.vsel = V_ABOVE;     sel.hsel = H_CENTER; end
            CC_ATTA_RIGHT:  begin sel.vsel = V_ABOVE;     sel.hsel = H_RIGHT;  end
            CC_BELOW_LEFT:  begin sel.vsel = V_BELOW_GAP; sel.hsel = H_LEFT;   end
            CC_BELOW, CC_KASRATAN, CC_KASRA:
                            begin sel.vsel = V_BELOW_GAP; sel.hsel = H_CENTER; end
            CC_BELOW_RIGHT: begin sel.vsel = V_BELOW_GAP; sel.hsel = H_RIGHT;  end
            CC_LEFT:        begin sel.vsel = V_KEEP;      sel.hsel = H_LEFT_OF_GAP;  end
            CC_RIGHT:       begin sel.vsel = V_KEEP;      sel.hsel = H_RIGHT_OF_GAP; end
            CC_ABOVE_LEFT:  begin sel.vsel = V_ABOVE_GAP; sel.hsel = H_LEFT;   end
            CC_ABOVE, CC_FATHATAN, CC_DAMMATAN, CC_FATHA, CC_DAMMA, CC_SHADDA, CC_SUKUN:
                            begin sel.vsel = V_ABOVE_GAP; sel.hsel = H_CENTER; end
            CC_ABOVE_RIGHT: begin sel.vsel = V_ABOVE_GAP; sel.hsel = H_RIGHT;  end
            default:        begin sel.vsel = V_KEEP;      sel.hsel = H_CENTER; end
        endcase
        return sel;
    endfunction

endpackage

// ===== sv/diacritic_attach_placer_core.sv =====
// diacritic_attach_placer_core: base-box tracking and mark placement.
// Depends on dap_pkg.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------------
//  item in  | start, busy (always 0)  | operation, rect_*, combining_class
//  result   | done (one-cycle strobe) | placed_left/top/right/bottom
//  config   | cfg_wr_en               | cfg_wr_data (font height)
//
// One beat per cycle. A place beat gives its result on done through the
// input register, then placement adders and saturation into the result
// register. Start and add beats update the base box from the input
// register, so a following place sees them. Reset clears the base box and
// loads the default font height gap. Results cannot be stalled.
module diacritic_attach_placer_core #(
    parameter int COORD_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          cfg_wr_en,
    input  logic [dap_pkg::FONT_BITS-1:0] cfg_wr_data,
    input  logic [1:0]                    operation,
    input  logic signed [COORD_BITS-1:0]  rect_left,
    input  logic signed [COORD_BITS-1:0]  rect_top,
    input  logic signed [COORD_BITS-1:0]  rect_right,
    input  logic signed [COORD_BITS-1:0]  rect_bottom,
    input  logic [7:0]                    combining_class,
    output logic                          done,
    output logic signed [COORD_BITS-1:0]  placed_left,
    output logic signed [COORD_BITS-1:0]  placed_top,
    output logic signed [COORD_BITS-1:0]  placed_right,
    output logic signed [COORD_BITS-1:0]  placed_bottom
);
    import dap_pkg::*;

    localparam int CW  = COORD_BITS;
    localparam int EXT = 4;
    localparam int XW  = CW + EXT;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [XW-1:0] wide_t;

    function automatic wide_t sx(input coord_t v);
        return {{EXT{v[CW-1]}}, v};
    endfunction

    function automatic coord_t sat(input wide_t v);
        logic [EXT:0] top;
        top = v[XW-1:CW-1];
        if (!v[XW-1] && (|top))
            return {1'b0, {(CW-1){1'b1}}};
        else if (v[XW-1] && !(&top))
            return {1'b1, {(CW-1){1'b0}}};
        else
            return v[CW-1:0];
    endfunction

    // config: gap = font_height / 10 by reciprocal multiply
    logic [GAP_BITS-1:0]      gap_reg;
    logic [GAP_PROD_BITS-1:0] gap_prod;

    assign gap_prod = GAP_PROD_BITS'(cfg_wr_data) * GAP_PROD_BITS'(GAP_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg <= GAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            gap_reg <= gap_prod[GAP_SHIFT +: GAP_BITS];
        end
    end

    // input register
    logic        in_valid_reg;
    logic [1:0]  op_reg;
    coord_t      rl_reg, rt_reg, rr_reg, rb_reg;
    place_sel_t  sel_reg;
    logic        accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= operation;
            rl_reg  <= rect_left;
            rt_reg  <= rect_top;
            rr_reg  <= rect_right;
            rb_reg  <= rect_bottom;
            sel_reg <= class_decode(combining_class);
        end
    end

    // base box
    coord_t base_left_reg, base_top_reg, base_right_reg, base_bottom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_left_reg   <= '0;
            base_top_reg    <= '0;
            base_right_reg  <= '0;
            base_bottom_reg <= '0;
        end
        else if (in_valid_reg)
        begin
            case (op_reg)
                OP_START:
                begin
                    base_left_reg   <= rl_reg;
                    base_top_reg    <= rt_reg;
                    base_right_reg  <= rr_reg;
                    base_bottom_reg <= rb_reg;
                end
                OP_ADD:
                begin
                    if (rl_reg < base_left_reg)   base_left_reg   <= rl_reg;
                    if (rt_reg < base_top_reg)    base_top_reg    <= rt_reg;
                    if (rr_reg > base_right_reg)  base_right_reg  <= rr_reg;
                    if (rb_reg > base_bottom_reg) base_bottom_reg <= rb_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    // placement
    wide_t w, h, gap, bl, bt, br, bb;
    wide_t diff, diff_adj, center, right_al, above, l, t;

    always_comb
    begin
        w   = sx(rr_reg) - sx(rl_reg);
        h   = sx(rb_reg) - sx(rt_reg);
        gap = {{(XW-GAP_BITS){1'b0}}, gap_reg};
        bl  = sx(base_left_reg);
        bt  = sx(base_top_reg);
        br  = sx(base_right_reg);
        bb  = sx(base_bottom_reg);

        // halve toward zero
        diff     = (br - bl) - w;
        diff_adj = diff + {{(XW-1){1'b0}}, diff[XW-1]};
        center   = bl + (diff_adj >>> 1);
        right_al = br - w;
        above    = bt - h;

        case (sel_reg.hsel)
            H_LEFT:         l = bl;
            H_CENTER:       l = center;
            H_RIGHT:        l = right_al;
            H_LEFT_OF:      l = bl - w;
            H_RIGHT_OF:     l = br;
            H_LEFT_OF_GAP:  l = bl - w - wide_t'(1);
            H_RIGHT_OF_GAP: l = br + wide_t'(1);
            default:        l = center;
        endcase

        case (sel_reg.vsel)
            V_KEEP:      t = sx(rt_reg);
            V_BELOW:     t = bb;
            V_ABOVE:     t = above;
            V_BELOW_GAP: t = bb + gap;
            V_ABOVE_GAP: t = above - gap;
            default:     t = sx(rt_reg);
        endcase
    end

    // result register
    logic   done_reg;
    coord_t pl_reg, pt_reg, pr_reg, pb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg && (op_reg == OP_PLACE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg && (op_reg == OP_PLACE))
        begin
            pl_reg <= sat(l);
            pt_reg <= sat(t);
            pr_reg <= sat(l + w);
            pb_reg <= sat(t + h);
        end
    end

    assign done          = done_reg;
    assign placed_left   = pl_reg;
    assign placed_top    = pt_reg;
    assign placed_right  = pr_reg;
    assign placed_bottom = pb_reg;

endmodule

// ===== sv/dap_checker.sv =====
// dap_checker: port-level checks for diacritic_attach_placer_core, bound to it.
// Depends on dap_pkg.
module dap_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] operation,
    input logic       done
);
    import dap_pkg::*;

    logic place_beat;

    assign place_beat = start && !busy && (operation == OP_PLACE);

    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy asserted");

    a_done_has_place: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(place_beat, 2))
        else $error("result strobe without a place beat");

    a_place_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(rst_n, 1) && $past(rst_n, 2) && $past(place_beat, 2)) |-> done)
        else $error("place beat lost");

    a_no_done_other_ops: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation != OP_PLACE)) |=> ##1 !done)
        else $error("result strobe after start, add or ignored beat");

endmodule

bind diacritic_attach_placer_core dap_checker u_dap_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .operation (operation),
    .done      (done)
);
